FILE: hw/rtl/stq_pkg.sv
// Shared types and constants for the sorted timer queue.
package stq_pkg;

   localparam int ID_W = 4;
   localparam int DUE_W = 64;
   localparam int PER_W = 32;
   localparam logic [13:0] PERIOD_SCALE = 14'd10000;

   typedef enum logic [1:0] {
      MODE_TICK   = 2'd0,
      MODE_SET    = 2'd1,
      MODE_CANCEL = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_ACK    = 2'd0,
      KIND_EXPIRE = 2'd1,
      KIND_TICK   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_REMOVE,
      CELL_INSERT
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_CHECK,
      ST_MUL,
      ST_REARM,
      ST_INSERT,
      ST_REMOVE,
      ST_ACK
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   id;
      logic [DUE_W-1:0]  due;
      logic [PER_W-1:0]  period;
      logic              notify;
   } entry_type;

   typedef struct packed {
      cell_op_type     op;
      logic [ID_W-1:0] key_id;
      entry_type       ent;
   } cell_cmd_type;

endpackage

FILE: hw/rtl/stq_cell.sv
// One queue position: holds one armed timer and shifts with its neighbors.
module stq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  stq_pkg::cell_cmd_type cmd,
   input  stq_pkg::entry_type   left_ent,
   input  stq_pkg::entry_type   right_ent,
   input  logic                 gt_in,
   output logic                 gt_out,
   input  logic                 mt_in,
   output logic                 mt_out,
   output stq_pkg::entry_type   ent_q
);

   stq_pkg::entry_type ent_ff;
   stq_pkg::entry_type ent_in;

   // empty position counts as later than any due time
   assign gt_out = !ent_ff.valid || (ent_ff.due > cmd.ent.due);
   assign mt_out = mt_in || (ent_ff.valid && (ent_ff.id == cmd.key_id));
   assign ent_q  = ent_ff;

   always_comb begin
      ent_in = ent_ff;
      case (cmd.op)
         stq_pkg::CELL_REMOVE: begin
            if (mt_out) ent_in = right_ent;
         end
         stq_pkg::CELL_INSERT: begin
            if (gt_in) ent_in = left_ent;
            else if (gt_out) ent_in = cmd.ent;
         end
         default: ent_in = ent_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else begin
         ent_ff <= ent_in;
      end
   end

endmodule

FILE: hw/rtl/sorted_timer_queue.sv
// Top level of the sorted timer queue: control sequencer and the cell row.
//
// Keeps a 64-bit system time and up to min(NUM_TIMERS,16) timers in a row of
// cells ordered by due time (unsigned), equal due times kept in arming order.
// Position 0 of the row is the next timer to expire. A remove or an insert
// shifts all cells past the affected position together, each taking its
// neighbor's entry. A cancel passes the remove and ack states, a set remove,
// insert and ack, a tick add and check; check pops each expired timer and
// re-arms a periodic one through mul, rearm and insert. The sequencer handles
// one item at a time; a new item is taken once the last result of the
// previous one sits in the output register. Re-arming multiplies the period
// by 10000, then adds the time next. At most SLOTS timers expire per tick.
module sorted_timer_queue #(
   parameter int NUM_TIMERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [3:0]  req_timer_id,
   input  logic [31:0] req_increment,
   input  logic signed [63:0] req_due_time,
   input  logic signed [31:0] req_period,
   input  logic        req_notify,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_timer_id_res,
   output logic        rsp_was_active,
   output logic [63:0] rsp_system_time,
   output logic        rsp_last
);

   localparam int SLOTS = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;
   localparam int CNT_W = $clog2(SLOTS + 1);

   stq_pkg::state_type state_ff, state_in;

   logic [63:0] time_ff;
   logic [1:0]  mode_ff;
   logic [3:0]  id_ff;
   logic [31:0] inc_ff;
   logic [63:0] due_ff;
   logic [31:0] per_ff;
   logic        ntf_ff;
   logic        was_ff;
   logic [CNT_W-1:0] done_ff;
   logic [63:0] prod_ff;
   logic [44:0] mul_p;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [3:0]  rsp_id_ff;
   logic        rsp_was_ff;
   logic [63:0] rsp_time_ff;
   logic        rsp_last_ff;

   // control decoded from the state
   logic        load_rsp;
   logic [1:0]  rsp_kind_in;
   logic [3:0]  rsp_id_in;
   logic        rsp_was_in;
   logic        rsp_last_in;
   logic        take_head;

   stq_pkg::cell_cmd_type cmd;
   stq_pkg::entry_type    ent [SLOTS+1];
   logic [SLOTS:0]        gt;
   logic [SLOTS:0]        mt;
   logic [SLOTS-1:0]      vbits;
   logic [SLOTS:0]        vplus;

   logic out_free;
   logic in_range;
   logic expire;
   logic rearm;
   logic accept;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign in_range = {1'b0, id_ff} < 5'(SLOTS);
   assign expire   = ent[0].valid && !(ent[0].due > time_ff)
                     && (done_ff < CNT_W'(SLOTS));
   assign rearm    = (ent[0].period != 32'd0) && !ent[0].period[31];
   assign mul_p    = per_ff[30:0] * stq_pkg::PERIOD_SCALE;

   // cell row: entry past the end reads as empty
   assign ent[SLOTS] = '0;
   assign gt[0] = 1'b0;
   assign mt[0] = 1'b0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      stq_pkg::entry_type left_e;
      stq_pkg::entry_type q_e;
      if (i == 0) begin : g_first
         assign left_e = '0;
      end else begin : g_rest
         assign left_e = ent[i-1];
      end
      stq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .left_ent  (left_e),
         .right_ent (ent[i+1]),
         .gt_in     (gt[i]),
         .gt_out    (gt[i+1]),
         .mt_in     (mt[i]),
         .mt_out    (mt[i+1]),
         .ent_q     (q_e)
      );
      assign ent[i]   = q_e;
      assign vbits[i] = q_e.valid;
   end

   assign vplus = {1'b0, vbits} + {{SLOTS{1'b0}}, 1'b1};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stq_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  stq_pkg::MODE_TICK:   state_in = stq_pkg::ST_ADD;
                  stq_pkg::MODE_SET,
                  stq_pkg::MODE_CANCEL: state_in = stq_pkg::ST_REMOVE;
                  default:              state_in = stq_pkg::ST_IDLE;
               endcase
            end
         end
         stq_pkg::ST_ADD: state_in = stq_pkg::ST_CHECK;
         stq_pkg::ST_CHECK: begin
            if (expire) begin
               if (!ent[0].notify || out_free)
                  state_in = rearm ? stq_pkg::ST_MUL : stq_pkg::ST_CHECK;
            end else if (out_free) begin
               state_in = stq_pkg::ST_IDLE;
            end
         end
         stq_pkg::ST_MUL:   state_in = stq_pkg::ST_REARM;
         stq_pkg::ST_REARM: state_in = stq_pkg::ST_INSERT;
         stq_pkg::ST_INSERT: begin
            state_in = (mode_ff == stq_pkg::MODE_TICK) ? stq_pkg::ST_CHECK
                                                       : stq_pkg::ST_ACK;
         end
         stq_pkg::ST_REMOVE: begin
            state_in = (mode_ff == stq_pkg::MODE_SET && in_range) ? stq_pkg::ST_INSERT
                                                                  : stq_pkg::ST_ACK;
         end
         stq_pkg::ST_ACK: begin
            if (out_free) state_in = stq_pkg::ST_IDLE;
         end
         default: state_in = stq_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready   = 1'b0;
      load_rsp    = 1'b0;
      rsp_kind_in = stq_pkg::KIND_ACK;
      rsp_id_in   = id_ff;
      rsp_was_in  = 1'b0;
      rsp_last_in = 1'b1;
      take_head   = 1'b0;
      cmd.op      = stq_pkg::CELL_HOLD;
      cmd.key_id  = id_ff;
      cmd.ent     = '{valid: 1'b1, id: id_ff, due: due_ff, period: per_ff, notify: ntf_ff};
      case (state_ff)
         stq_pkg::ST_IDLE: req_ready = 1'b1;
         stq_pkg::ST_CHECK: begin
            if (expire) begin
               if (!ent[0].notify || out_free) begin
                  // pop the head and report it if asked to
                  take_head  = 1'b1;
                  cmd.op     = stq_pkg::CELL_REMOVE;
                  cmd.key_id = ent[0].id;
                  if (ent[0].notify) begin
                     load_rsp    = 1'b1;
                     rsp_kind_in = stq_pkg::KIND_EXPIRE;
                     rsp_id_in   = ent[0].id;
                     rsp_last_in = 1'b0;
                  end
               end
            end else if (out_free) begin
               load_rsp    = 1'b1;
               rsp_kind_in = stq_pkg::KIND_TICK;
               rsp_id_in   = 4'd0;
            end
         end
         stq_pkg::ST_INSERT: cmd.op = stq_pkg::CELL_INSERT;
         stq_pkg::ST_REMOVE: begin
            if (in_range) cmd.op = stq_pkg::CELL_REMOVE;
         end
         stq_pkg::ST_ACK: begin
            if (out_free) begin
               load_rsp   = 1'b1;
               rsp_was_in = was_ff;
            end
         end
         default: req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stq_pkg::ST_IDLE;
         time_ff      <= 64'd0;
         rsp_valid_ff <= 1'b0;
         done_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (state_ff == stq_pkg::ST_ADD) time_ff <= time_ff + {32'd0, inc_ff};
         if (accept) done_ff <= '0;
         else if (take_head) done_ff <= done_ff + 1'b1;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         id_ff   <= req_timer_id;
         inc_ff  <= req_increment;
         due_ff  <= req_due_time;
         per_ff  <= req_period;
         ntf_ff  <= req_notify;
      end
      if (take_head) begin
         id_ff  <= ent[0].id;
         per_ff <= ent[0].period;
         ntf_ff <= ent[0].notify;
      end
      if (state_ff == stq_pkg::ST_REMOVE) begin
         was_ff <= in_range && mt[SLOTS];
         // negative due time is a delay from now
         if (due_ff[63]) due_ff <= time_ff - due_ff;
      end
      if (state_ff == stq_pkg::ST_MUL)   prod_ff <= {19'd0, mul_p};
      if (state_ff == stq_pkg::ST_REARM) due_ff  <= time_ff + prod_ff;
      if (load_rsp) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_id_ff   <= rsp_id_in;
         rsp_was_ff  <= rsp_was_in;
         rsp_time_ff <= time_ff;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_timer_id_res = rsp_id_ff;
   assign rsp_was_active   = rsp_was_ff;
   assign rsp_system_time  = rsp_time_ff;
   assign rsp_last         = rsp_last_ff;

   // armed timers always fill the row from position 0 without gaps
   a_packed_row: assert property (@(posedge clock) disable iff (reset)
      $onehot(vplus)) else $error("queue row has a gap");

   // a timer is never inserted while a copy of it is still queued
   a_no_dup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == stq_pkg::ST_INSERT) |-> !mt[SLOTS])
      else $error("duplicate timer inserted");

   // expiry count per tick stays bounded by the queue size
   a_done_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff <= CNT_W'(SLOTS)) else $error("expiry count overflow");

endmodule
